// ----- src/pbtos_pkg.sv -----
`timescale 1ns / 1ps
package pbtos_pkg;

   localparam int BUCKET_W  = 6;
   localparam int WORD_W    = 32;
   localparam int MAT_W     = 15;
   localparam int CORNER_W  = 16;
   localparam int MCOUNT_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MATERIAL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDE_ENABLE    = 1'b1;

   localparam logic [CORNER_W-1:0] CORNERS_PER_FAN = 16'd2;

   typedef enum logic [1:0] {
      FUNC_COUNT  = 2'd0,
      FUNC_FINISH = 2'd1,
      FUNC_PLACE  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      KIND_PLACE  = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   // operation broadcast along the row of cells
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_COUNT  = 3'd1,
      OP_PLACE  = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_SUM    = 3'd4,
      OP_REPORT = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [BUCKET_W-1:0] sel;
      logic [CORNER_W-1:0] tris;
   } cell_ctl_type;

   typedef struct packed {
      kind_type            kind;
      logic [BUCKET_W-1:0] bucket;
      logic [WORD_W-1:0]   first_triangle;
      logic                is_hidden;
      logic [WORD_W-1:0]   bucket_triangles;
      logic [WORD_W-1:0]   bucket_offset;
      logic [WORD_W-1:0]   visible_total;
      logic                overflow;
      logic                last;
   } rsp_payload_type;

endpackage

// ----- src/pbtos_req_if.sv -----
`timescale 1ns / 1ps
interface pbtos_req_if import pbtos_pkg::*;;
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [MAT_W-1:0]    material;
   logic [CORNER_W-1:0] corner_count;
   logic                hidden;

   modport source (output valid, func, material, corner_count, hidden, input ready);
   modport sink   (input valid, func, material, corner_count, hidden, output ready);
endinterface

// ----- src/pbtos_rsp_if.sv -----
`timescale 1ns / 1ps
interface pbtos_rsp_if import pbtos_pkg::*;;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BUCKET_W-1:0] bucket;
   logic [WORD_W-1:0]   first_triangle;
   logic                is_hidden;
   logic [WORD_W-1:0]   bucket_triangles;
   logic [WORD_W-1:0]   bucket_offset;
   logic [WORD_W-1:0]   visible_total;
   logic                overflow;
   logic                last;

   modport source (output valid, kind, bucket, first_triangle, is_hidden, bucket_triangles,
                   bucket_offset, visible_total, overflow, last, input ready);
   modport sink   (input valid, kind, bucket, first_triangle, is_hidden, bucket_triangles,
                   bucket_offset, visible_total, overflow, last, output ready);
endinterface

// ----- src/pbtos_csr_if.sv -----
`timescale 1ns / 1ps
interface pbtos_csr_if import pbtos_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MCOUNT_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pbtos_cell.sv -----
`timescale 1ns / 1ps
module pbtos_cell import pbtos_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [WORD_W-1:0] chain_in,
   output logic [WORD_W-1:0] chain_out,
   output logic [WORD_W-1:0] chain_next,
   output logic [WORD_W-1:0] count_out,
   output logic [WORD_W-1:0] cursor_out,
   output logic              ovf
);

   logic [WORD_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0] cursor_ff, cursor_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] add_a, add_b, res;
   logic [WORD_W:0]   add_full;
   logic              hit;

   assign hit = (ctl.sel == BUCKET_W'(IDX));

   always_comb begin
      add_a = '0;
      add_b = '0;
      case (ctl.op)
         OP_COUNT: begin
            add_a = count_ff;
            add_b = WORD_W'(ctl.tris);
         end
         OP_PLACE: begin
            add_a = cursor_ff;
            add_b = WORD_W'(ctl.tris);
         end
         OP_SUM, OP_REPORT: begin
            add_a = chain_in;
            add_b = count_ff;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
      add_full = {1'b0, add_a} + {1'b0, add_b};
      // saturate at all ones
      res = add_full[WORD_W] ? '1 : add_full[WORD_W-1:0];
      ovf = hit && add_full[WORD_W];
   end

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      sum_in    = sum_ff;
      case (ctl.op)
         OP_CLEAR: begin
            count_in  = '0;
            cursor_in = '0;
         end
         OP_COUNT: begin
            if (hit) count_in = res;
         end
         OP_PLACE: begin
            if (hit) cursor_in = res;
         end
         OP_SUM: begin
            if (hit) sum_in = res;
         end
         OP_REPORT: begin
            if (hit) begin
               cursor_in = chain_in;
               sum_in    = res;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      sum_ff <= sum_in;
   end

   assign chain_out  = sum_ff;
   assign chain_next = res;
   assign count_out  = count_ff;
   assign cursor_out = cursor_ff;

endmodule

// ----- src/per_bucket_triangle_offset_sort_top.sv -----
`timescale 1ns / 1ps
// Counting sort of polygons into material buckets, measured in triangles. A row of
// MAX_BUCKETS cells holds each bucket's triangle count and placement cursor. Count
// and place items need no walk, as the addressed cell does its own saturating add;
// a clear item zeroes every cell's count and cursor. A place result lands in the
// output register at once (the item is taken when that register is empty or being
// emptied). A finish item walks a running sum along the cells twice, one cell per
// cycle: first to form the visible total, then to hand each cell its exclusive
// offset while one bucket report leaves per cycle unless the output stalls, which
// also holds the walk; the input is held through both walks and any output stall.
// Configuration registers: index 0 material_count, index 1 hide_enable.
module per_bucket_triangle_offset_sort_top import pbtos_pkg::*; #(
   parameter int MAX_BUCKETS = 64
) (
   input logic        clock,
   input logic        reset,
   pbtos_req_if.sink   req_ch,
   pbtos_rsp_if.source rsp_ch,
   pbtos_csr_if.sink   csr_ch
);

   localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SUM    = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     walk_ff, walk_in;
   logic [WORD_W-1:0]    total_ff, total_in;
   logic                 sat_ff, sat_in;
   logic [MCOUNT_W-1:0]  mcount_ff;
   logic                 hide_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   cell_ctl_type         ctl;
   logic [WORD_W-1:0]    chain_in_w   [MAX_BUCKETS];
   logic [WORD_W-1:0]    chain_out_w  [MAX_BUCKETS];
   logic [WORD_W-1:0]    chain_next_w [MAX_BUCKETS];
   logic [WORD_W-1:0]    count_w      [MAX_BUCKETS];
   logic [WORD_W-1:0]    cursor_w     [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] ovf_w;
   logic                 ovf_any;

   logic [IDX_W-1:0]     last_idx;
   logic [IDX_W-1:0]     bucket_idx;
   logic [CORNER_W-1:0]  tris;
   logic                 skip;
   logic                 slot_free;
   logic                 accept;
   logic                 clear_now;

   // row of cells
   for (genvar i = 0; i < MAX_BUCKETS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign chain_in_w[i] = '0;
      end else begin : g_link
         assign chain_in_w[i] = chain_out_w[i-1];
      end
      pbtos_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .chain_in   (chain_in_w[i]),
         .chain_out  (chain_out_w[i]),
         .chain_next (chain_next_w[i]),
         .count_out  (count_w[i]),
         .cursor_out (cursor_w[i]),
         .ovf        (ovf_w[i])
      );
   end

   assign ovf_any = |ovf_w;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff <= MCOUNT_W'(1);
         hide_ff   <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MATERIAL_COUNT: mcount_ff <= csr_ch.data;
            CSR_HIDE_ENABLE:    hide_ff   <= csr_ch.data[0];
            default:            hide_ff   <= hide_ff;
         endcase
      end
   end

   // buckets in use, clamped to 1..MAX_BUCKETS
   always_comb begin
      if (mcount_ff == '0) begin
         last_idx = '0;
      end else if (mcount_ff > MCOUNT_W'(MAX_BUCKETS)) begin
         last_idx = IDX_W'(MAX_BUCKETS - 1);
      end else begin
         last_idx = IDX_W'(mcount_ff - MCOUNT_W'(1));
      end
      if (req_ch.material < MAT_W'(last_idx)) begin
         bucket_idx = req_ch.material[IDX_W-1:0];
      end else begin
         bucket_idx = last_idx;
      end
      tris = (req_ch.corner_count >= CORNERS_PER_FAN) ?
             (req_ch.corner_count - CORNERS_PER_FAN) : '0;
      skip = req_ch.hidden && hide_ff;
   end

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign clear_now    = accept && (func_type'(req_ch.func) == FUNC_CLEAR);

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ctl.op       = OP_NONE;
      ctl.sel      = BUCKET_W'(bucket_idx);
      ctl.tris     = tris;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func_type'(req_ch.func))
                  FUNC_COUNT: begin
                     if (!skip) ctl.op = OP_COUNT;
                  end
                  FUNC_PLACE: begin
                     if (!skip) ctl.op = OP_PLACE;
                     rsp_valid_in           = 1'b1;
                     rsp_in.kind            = KIND_PLACE;
                     rsp_in.bucket          = BUCKET_W'(bucket_idx);
                     rsp_in.first_triangle  = skip ? '0 : cursor_w[bucket_idx];
                     rsp_in.is_hidden       = skip;
                     rsp_in.bucket_triangles = '0;
                     rsp_in.bucket_offset   = '0;
                     rsp_in.visible_total   = total_ff;
                     rsp_in.overflow        = sat_ff || ovf_any;
                     rsp_in.last            = 1'b1;
                  end
                  FUNC_CLEAR: begin
                     ctl.op   = OP_CLEAR;
                     total_in = '0;
                  end
                  FUNC_FINISH: begin
                     state_in = ST_SUM;
                     walk_in  = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUM: begin
            ctl.op  = OP_SUM;
            ctl.sel = BUCKET_W'(walk_ff);
            if (walk_ff == last_idx) begin
               total_in = chain_next_w[walk_ff];
               state_in = ST_REPORT;
               walk_in  = '0;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               ctl.op                  = OP_REPORT;
               ctl.sel                 = BUCKET_W'(walk_ff);
               rsp_valid_in            = 1'b1;
               rsp_in.kind             = KIND_REPORT;
               rsp_in.bucket           = BUCKET_W'(walk_ff);
               rsp_in.first_triangle   = '0;
               rsp_in.is_hidden        = 1'b0;
               rsp_in.bucket_triangles = count_w[walk_ff];
               rsp_in.bucket_offset    = chain_in_w[walk_ff];
               rsp_in.visible_total    = total_ff;
               rsp_in.overflow         = sat_ff;
               rsp_in.last             = (walk_ff == last_idx);
               if (walk_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  walk_in = walk_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign sat_in = clear_now ? 1'b0 : (sat_ff || ovf_any);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.kind             = rsp_ff.kind;
   assign rsp_ch.bucket           = rsp_ff.bucket;
   assign rsp_ch.first_triangle   = rsp_ff.first_triangle;
   assign rsp_ch.is_hidden        = rsp_ff.is_hidden;
   assign rsp_ch.bucket_triangles = rsp_ff.bucket_triangles;
   assign rsp_ch.bucket_offset    = rsp_ff.bucket_offset;
   assign rsp_ch.visible_total    = rsp_ff.visible_total;
   assign rsp_ch.overflow         = rsp_ff.overflow;
   assign rsp_ch.last             = rsp_ff.last;

`ifndef SYNTHESIS
   // the walking sum never runs past the last bucket in use
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (walk_ff <= last_idx))
      else $error("walk index beyond buckets in use");

   // only the addressed cell may saturate in a cycle
   a_one_ovf: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ovf_w))
      else $error("more than one cell saturated");

   // the overflow flag drops only through a clear transfer
   a_sat_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(sat_ff) |-> $past(clear_now))
      else $error("overflow flag dropped without clear");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import pbtos_pkg::*;

   localparam int MAX_BUCKETS   = 64;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int BURST_ITEMS   = 12;

   typedef struct packed {
      logic                 cfg_write;
      logic [CSR_IDX_W-1:0] cfg_index;
      logic [MCOUNT_W-1:0]  cfg_data;
      func_type             func;
      logic [MAT_W-1:0]     material;
      logic [CORNER_W-1:0]  corners;
      logic                 hidden;
      logic                 typed;
      rsp_payload_type      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbtos_req_if req_ch ();
   pbtos_rsp_if rsp_ch ();
   pbtos_csr_if csr_ch ();

   per_bucket_triangle_offset_sort_top #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // predicted block state
   bit [WORD_W-1:0]   tri_count    [MAX_BUCKETS];
   bit [WORD_W-1:0]   place_cursor [MAX_BUCKETS];
   bit [WORD_W-1:0]   latched_total;
   bit                count_saturated;
   bit [MCOUNT_W-1:0] bucket_limit_reg = 7'd1;
   bit                hide_reg;

   rsp_payload_type expected_rsp [$];
   rsp_payload_type head_rsp;
   stim_row_type    directed_rows [$];

   logic            typed_on  = 1'b0;
   rsp_payload_type typed_rsp = '0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   bit              steady_send = 1'b0;
   bit              hold_req = 1'b0;

   function automatic logic [WORD_W-1:0] add_clamped(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[WORD_W]) begin
         count_saturated = 1'b1;
         return '1;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic int unsigned buckets_in_use(input logic [MCOUNT_W-1:0] limit);
      if (limit == 0) return 1;
      if (limit > MAX_BUCKETS) return MAX_BUCKETS;
      return limit;
   endfunction

   function automatic void sort_predict(input func_type f, input logic [MAT_W-1:0] mat,
                                        input logic [CORNER_W-1:0] corners,
                                        input logic hid);
      int unsigned     n;
      int unsigned     b;
      logic [WORD_W-1:0] tris;
      logic [WORD_W-1:0] off;
      logic [WORD_W-1:0] sum;
      logic            skip;
      rsp_payload_type r;
      n    = buckets_in_use(bucket_limit_reg);
      b    = (mat < n - 1) ? mat : n - 1;
      tris = (corners >= CORNERS_PER_FAN) ? WORD_W'(corners - CORNERS_PER_FAN) : '0;
      skip = hid && hide_reg;
      case (f)
         FUNC_COUNT: begin
            if (!skip) tri_count[b] = add_clamped(tri_count[b], tris);
         end
         FUNC_FINISH: begin
            sum = '0;
            for (int i = 0; i < n; i++) sum = add_clamped(sum, tri_count[i]);
            latched_total = sum;
            off = '0;
            for (int i = 0; i < n; i++) begin
               place_cursor[i]    = off;
               r                  = '0;
               r.kind             = KIND_REPORT;
               r.bucket           = 6'(i);
               r.bucket_triangles = tri_count[i];
               r.bucket_offset    = off;
               r.visible_total    = sum;
               r.overflow         = count_saturated;
               r.last             = (i == n - 1);
               expected_rsp.push_back(r);
               off = add_clamped(off, tri_count[i]);
            end
         end
         FUNC_PLACE: begin
            r               = '0;
            r.kind          = KIND_PLACE;
            r.bucket        = 6'(b);
            r.visible_total = latched_total;
            r.last          = 1'b1;
            if (skip) begin
               r.is_hidden = 1'b1;
            end else begin
               off             = place_cursor[b];
               place_cursor[b] = add_clamped(off, tris);
               r.first_triangle = off;
            end
            // overflow reflects the cursor advance of this very item
            r.overflow = count_saturated;
            expected_rsp.push_back(r);
         end
         default: begin
            for (int i = 0; i < MAX_BUCKETS; i++) begin
               tri_count[i]    = '0;
               place_cursor[i] = '0;
            end
            latched_total   = '0;
            count_saturated = 1'b0;
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // csr writes, accepted items and results, all seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_MATERIAL_COUNT: bucket_limit_reg = csr_ch.data;
               CSR_HIDE_ENABLE:    hide_reg = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            sort_predict(func_type'(req_ch.func), req_ch.material, req_ch.corner_count,
                         req_ch.hidden);
            if (typed_on && expected_rsp.size() != 0) begin
               void'(expected_rsp.pop_back());
               expected_rsp.push_back(typed_rsp);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 40)
                  $display("%0t: result transfer expected none actual bucket %0d",
                           $time, rsp_ch.bucket);
            end else begin
               head_rsp = expected_rsp.pop_front();
               compare_field("kind", WORD_W'(head_rsp.kind), WORD_W'(rsp_ch.kind));
               compare_field("bucket", WORD_W'(head_rsp.bucket), WORD_W'(rsp_ch.bucket));
               compare_field("first_triangle", head_rsp.first_triangle,
                             rsp_ch.first_triangle);
               compare_field("is_hidden", WORD_W'(head_rsp.is_hidden),
                             WORD_W'(rsp_ch.is_hidden));
               compare_field("bucket_triangles", head_rsp.bucket_triangles,
                             rsp_ch.bucket_triangles);
               compare_field("bucket_offset", head_rsp.bucket_offset, rsp_ch.bucket_offset);
               compare_field("visible_total", head_rsp.visible_total, rsp_ch.visible_total);
               compare_field("overflow", WORD_W'(head_rsp.overflow),
                             WORD_W'(rsp_ch.overflow));
               compare_field("last", WORD_W'(head_rsp.last), WORD_W'(rsp_ch.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: ready runs and stalls of random length, plus a long hold on request
   initial begin
      int run;
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            if ($urandom_range(7) == 0) begin
               run   = 60;
               stall = 0;
            end else begin
               run   = $urandom_range(8, 1);
               stall = $urandom_range(3);
            end
            rsp_ch.ready = 1'b1;
            repeat (run) @(negedge clock);
            if (stall > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
      end
   end

   task automatic send_item(input func_type f, input logic [MAT_W-1:0] m,
                            input logic [CORNER_W-1:0] c, input logic h,
                            input logic typed, input rsp_payload_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(12, 1);
         gap = steady_send ? 0 : $urandom_range(4, 1);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.func         = f;
      req_ch.material     = m;
      req_ch.corner_count = c;
      req_ch.hidden       = h;
      typed_on            = typed;
      typed_rsp           = want;
      req_ch.valid        = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input func_type f, input int unsigned n_eff);
      logic [MAT_W-1:0]    m;
      logic [CORNER_W-1:0] c;
      logic                h;
      // mostly buckets in use and one past, now and then any material
      m = ($urandom_range(3) != 0) ? MAT_W'($urandom_range(n_eff))
                                   : MAT_W'($urandom_range(32767));
      case ($urandom_range(7))
         0:       c = CORNER_W'($urandom_range(2));
         1:       c = CORNER_W'($urandom);
         default: c = CORNER_W'($urandom_range(40, 3));
      endcase
      h = ($urandom_range(3) == 0);
      send_item(f, m, c, h, 1'b0, '0);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [MCOUNT_W-1:0] d);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = d;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic rsp_payload_type placed(input logic [BUCKET_W-1:0] bk,
                                              input logic [WORD_W-1:0] first,
                                              input logic hid,
                                              input logic [WORD_W-1:0] total);
      rsp_payload_type r;
      r                = '0;
      r.kind           = KIND_PLACE;
      r.bucket         = bk;
      r.first_triangle = first;
      r.is_hidden      = hid;
      r.visible_total  = total;
      r.last           = 1'b1;
      return r;
   endfunction

   // single-bucket report, bucket 0
   function automatic rsp_payload_type reported(input logic [WORD_W-1:0] tri_cnt,
                                                input logic [WORD_W-1:0] off,
                                                input logic [WORD_W-1:0] total);
      rsp_payload_type r;
      r                  = '0;
      r.kind             = KIND_REPORT;
      r.bucket_triangles = tri_cnt;
      r.bucket_offset    = off;
      r.visible_total    = total;
      r.last             = 1'b1;
      return r;
   endfunction

   task automatic add_row(input func_type f, input logic [MAT_W-1:0] m,
                          input logic [CORNER_W-1:0] c, input logic h);
      stim_row_type row;
      row          = '0;
      row.func     = f;
      row.material = m;
      row.corners  = c;
      row.hidden   = h;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(input func_type f, input logic [MAT_W-1:0] m,
                            input logic [CORNER_W-1:0] c, input logic h,
                            input rsp_payload_type want);
      add_row(f, m, c, h);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want  = want;
   endtask

   task automatic add_cfg(input logic [CSR_IDX_W-1:0] idx, input logic [MCOUNT_W-1:0] d);
      stim_row_type row;
      row           = '0;
      row.cfg_write = 1'b1;
      row.cfg_index = idx;
      row.cfg_data  = d;
      directed_rows.push_back(row);
   endtask

   initial begin
      int unsigned      n_eff;
      int               n_counts;
      int               n_places;
      logic [MCOUNT_W-1:0] mc;
      stim_row_type     row;

      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_COUNT;
      req_ch.material     = '0;
      req_ch.corner_count = '0;
      req_ch.hidden       = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_MATERIAL_COUNT;
      csr_ch.data         = '0;

      // one bucket after reset, hiding off
      add_typed(FUNC_PLACE,  15'd0,      16'd3,     1'b0, placed(6'd0, 32'd0, 1'b0, 32'd0));
      add_typed(FUNC_FINISH, 15'd0,      16'd0,     1'b0, reported(32'd0, 32'd0, 32'd0));
      add_row  (FUNC_COUNT,  15'h7FFF,   16'hFFFF,  1'b1);
      add_row  (FUNC_COUNT,  15'd0,      16'd3,     1'b0);
      add_row  (FUNC_COUNT,  15'd0,      16'd0,     1'b0);
      add_row  (FUNC_COUNT,  15'd0,      16'd2,     1'b0);
      add_typed(FUNC_FINISH, 15'd0,      16'd0,     1'b0,
                reported(32'd65534, 32'd0, 32'd65534));
      add_typed(FUNC_PLACE,  15'd5,      16'd10,    1'b0,
                placed(6'd0, 32'd0, 1'b0, 32'd65534));
      add_typed(FUNC_PLACE,  15'd0,      16'hFFFF,  1'b1,
                placed(6'd0, 32'd8, 1'b0, 32'd65534));
      add_row  (FUNC_CLEAR,  15'd0,      16'd0,     1'b0);
      add_typed(FUNC_PLACE,  15'd0,      16'd1,     1'b0, placed(6'd0, 32'd0, 1'b0, 32'd0));
      // bucket count of zero behaves as one; hiding on
      add_cfg(CSR_MATERIAL_COUNT, 7'd0);
      add_cfg(CSR_HIDE_ENABLE, 1'b1);
      add_row  (FUNC_COUNT,  15'd3,      16'd5,     1'b1);
      add_typed(FUNC_PLACE,  15'd0,      16'd5,     1'b1, placed(6'd0, 32'd0, 1'b1, 32'd0));
      add_typed(FUNC_FINISH, 15'd0,      16'd0,     1'b0, reported(32'd0, 32'd0, 32'd0));
      // bucket count above the maximum
      add_cfg(CSR_MATERIAL_COUNT, 7'd127);
      add_row  (FUNC_COUNT,  15'h7FFF,   16'd100,   1'b0);
      add_row  (FUNC_COUNT,  15'd1,      16'd4,     1'b0);
      add_row  (FUNC_COUNT,  15'd40,     16'd7,     1'b1);
      add_row  (FUNC_FINISH, 15'd0,      16'd0,     1'b0);
      add_row  (FUNC_PLACE,  15'd63,     16'd8,     1'b0);
      // fewer buckets between the passes
      add_cfg(CSR_MATERIAL_COUNT, 7'd64);
      add_cfg(CSR_MATERIAL_COUNT, 7'd2);
      add_row  (FUNC_FINISH, 15'd0,      16'd0,     1'b0);
      add_row  (FUNC_PLACE,  15'd50,     16'd6,     1'b0);
      add_cfg(CSR_HIDE_ENABLE, 1'b0);
      add_row  (FUNC_PLACE,  15'd40,     16'd7,     1'b1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.cfg_write) begin
            quiesce();
            write_csr(row.cfg_index, row.cfg_data);
         end else begin
            send_item(row.func, row.material, row.corners, row.hidden, row.typed, row.want);
         end
      end

      // back-to-back large counts into bucket 0, then finish and places over two buckets
      quiesce();
      write_csr(CSR_MATERIAL_COUNT, 7'd2);
      send_item(FUNC_CLEAR, 15'd0, 16'd0, 1'b0, 1'b0, '0);
      steady_send = 1'b1;
      repeat (BURST_ITEMS) send_item(FUNC_COUNT, 15'd0, 16'hFFFF, 1'b0, 1'b0, '0);
      steady_send = 1'b0;
      send_item(FUNC_COUNT,  15'd1, 16'd1002, 1'b0, 1'b0, '0);
      send_item(FUNC_FINISH, 15'd0, 16'd0,    1'b0, 1'b0, '0);
      send_item(FUNC_PLACE,  15'd0, 16'd10,   1'b0, 1'b0, '0);
      send_item(FUNC_PLACE,  15'd1, 16'd5,    1'b0, 1'b0, '0);
      send_item(FUNC_PLACE,  15'd1, 16'd5,    1'b0, 1'b0, '0);
      send_item(FUNC_CLEAR,  15'd0, 16'd0,    1'b0, 1'b0, '0);
      send_item(FUNC_PLACE,  15'd0, 16'd3,    1'b0, 1'b0, '0);

      // clear, count pass, finish, place pass, with stray items mixed in
      for (int phase = 0; phase < 5; phase++) begin
         quiesce();
         case (phase)
            0:       mc = 7'd1;
            1:       mc = 7'd64;
            2:       mc = 7'd0;
            3:       mc = 7'd127;
            default: mc = MCOUNT_W'($urandom_range(63, 2));
         endcase
         write_csr(CSR_MATERIAL_COUNT, mc);
         write_csr(CSR_HIDE_ENABLE, MCOUNT_W'($urandom_range(1)));
         n_eff    = buckets_in_use(mc);
         n_counts = $urandom_range(8, 3);
         n_places = $urandom_range(6, 3);
         send_item(FUNC_CLEAR, 15'd0, 16'd0, 1'b0, 1'b0, '0);
         for (int i = 0; i < n_counts; i++) begin
            if ($urandom_range(7) == 0) send_random(func_type'($urandom_range(3)), n_eff);
            send_random(FUNC_COUNT, n_eff);
         end
         // long receiver hold while finish and places keep coming
         if (phase == 1) hold_req = 1'b1;
         send_item(FUNC_FINISH, MAT_W'($urandom), CORNER_W'($urandom), 1'($urandom), 1'b0, '0);
         for (int i = 0; i < n_places; i++) begin
            if ($urandom_range(7) == 0) send_random(func_type'($urandom_range(3)), n_eff);
            send_random(FUNC_PLACE, n_eff);
         end
      end

      quiesce();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
